@@ hdl/binary_matrix_upscale_packer_assert.svh @@
// ============================================================================
// Assertion macros for the binary matrix upscale packer
// Concurrent checks that compile away in synthesis.
// ============================================================================
`ifndef BINARY_MATRIX_UPSCALE_PACKER_ASSERT_SVH
`define BINARY_MATRIX_UPSCALE_PACKER_ASSERT_SVH
`ifndef SYNTHESIS
// condition must never hold
`define BMUP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bmup check failed");
// antecedent implies consequent in the next cycle
`define BMUP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmup check failed");
// antecedent implies consequent in the same cycle
`define BMUP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmup check failed");
`else
`define BMUP_ASSERT_NEVER(lbl, clk, rst_n, cond)
`define BMUP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define BMUP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/bmup_pkg.sv @@
// ============================================================================
// bmup_pkg
// Shared types, codes and width helpers of the upscale packer.
// ============================================================================
package bmup_pkg;

    localparam int MAX_MODULES_DEF = 177;
    localparam int MAX_IMAGE_DEF   = 4096;
    localparam int WORD_BITS_DEF   = 32;

    localparam int ROW_W   = 12;
    localparam int COL_W   = 9;
    localparam int BITS_W  = 32;
    localparam int PIX_W   = 8;
    localparam int LANES   = 8;
    localparam int LANE_W  = 3;
    localparam int CFG_W   = 13;
    localparam int BW_W    = 8;
    localparam int MC_W    = 8;
    localparam int IS_W    = 13;
    localparam int IDX_W   = 2;
    localparam int SDATA_W = 56;

    localparam logic [MC_W-1:0] MC_RST = 8'd21;
    localparam logic [BW_W-1:0] BW_RST = 8'd4;
    localparam logic [IS_W-1:0] IS_RST = 13'd0;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DOWNSCALE = 2'd1,
        ST_RANGE     = 2'd2
    } t_status;

    typedef enum logic [IDX_W-1:0] {
        CFG_MODULE_COUNT = 2'd0,
        CFG_BORDER       = 2'd1,
        CFG_IMAGE_SIDE   = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } t_op;

    // classified transaction as it sits in the queue
    typedef struct packed {
        t_op               op;
        logic              wr_ok;
        t_status           status;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [BITS_W-1:0] bits;
    } t_item;

    // effective module count width
    function automatic int f_nw(input int mm);
        return $clog2(mm + 1);
    endfunction

    // bordered grid side width (border up to 255 on each side)
    function automatic int f_totw(input int mm);
        return $clog2(mm + 2 * 255 + 1);
    endfunction

    // image side width, wide enough to also hold the bordered grid side
    function automatic int f_siw(input int mm, input int mi);
        int a;
        int b;
        a = $clog2(mi + 1);
        b = $clog2(mm + 2 * 255 + 1);
        return (a > b) ? a : b;
    endfunction

endpackage

@@ hdl/binary_matrix_upscale_packer.sv @@
// ============================================================================
// binary_matrix_upscale_packer
// Nearest-neighbor upscaler of a bordered module matrix to 1-bpp packed bytes.
// ============================================================================
// Loads and byte reads both enter on the slave stream; each read gives one
// byte on the master stream, one transaction per clock sustained while both
// tready are high; a read goes through the queue, stage 1, stage 2 and the
// output register. The pixel-to-module map table is rebuilt after reset and
// every register write by a one-pixel-per-clock sweep over MAX_IMAGE rounded
// up to a multiple of 8, with s_tready low. Write registers only when idle.
module binary_matrix_upscale_packer
    import bmup_pkg::*;
#(
    parameter int MAX_MODULES = MAX_MODULES_DEF,
    parameter int MAX_IMAGE   = MAX_IMAGE_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
)(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    // row_index[11:0], column_index[20:12], module_bits[52:21], zero pad
    input  logic [SDATA_W-1:0] s_tdata,
    // opcode[0]
    input  logic [0:0]         s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // pixel_byte[7:0]
    output logic [PIX_W-1:0]   m_tdata,
    // status[1:0]
    output logic [1:0]         m_tuser,
    input  logic               i_cfg_we,
    input  logic [IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    localparam int NW   = f_nw(MAX_MODULES);
    localparam int TOTW = f_totw(MAX_MODULES);
    localparam int SIW  = f_siw(MAX_MODULES, MAX_IMAGE);

    logic [MC_W-1:0] r_mc;
    logic [BW_W-1:0] r_bw;
    logic [IS_W-1:0] r_is;

    logic [NW-1:0]   n_n;
    logic [TOTW-1:0] n_tot;
    logic [SIW-1:0]  n_sat;
    logic [SIW-1:0]  n_side;
    logic [SIW:0]    n_bpr;
    logic [NW-1:0]   r_n;
    logic [TOTW-1:0] r_tot;
    logic [SIW-1:0]  r_side;
    logic [SIW-1:0]  r_bpr;
    logic            r_dn;

    logic    busy;
    logic    q_full;
    logic    q_valid;
    logic    push;
    logic    pop;
    t_item   f_item;
    t_item   q_item;
    t_status o_st;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mc <= MC_RST;
            r_bw <= BW_RST;
            r_is <= IS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODULE_COUNT: r_mc <= i_cfg_data[MC_W-1:0];
                CFG_BORDER:       r_bw <= i_cfg_data[BW_W-1:0];
                CFG_IMAGE_SIDE:   r_is <= i_cfg_data[IS_W-1:0];
                default:          r_mc <= r_mc;
            endcase
        end
    end

    // effective geometry
    always_comb begin
        n_n    = (32'(r_mc) > 32'(MAX_MODULES)) ? NW'(MAX_MODULES) : NW'(r_mc);
        n_tot  = TOTW'(n_n) + TOTW'({r_bw, 1'b0});
        n_sat  = (32'(r_is) > 32'(MAX_IMAGE)) ? SIW'(MAX_IMAGE) : SIW'(r_is);
        n_side = (n_sat == '0) ? SIW'(n_tot) : n_sat;
        n_bpr  = ({1'b0, n_side} + (SIW+1)'(7)) >> 3;
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_tot  <= n_tot;
        r_side <= n_side;
        r_bpr  <= n_bpr[SIW-1:0];
        r_dn   <= (SIW'(n_tot) > n_side);
    end

    bmup_front #(
        .MAX_MODULES (MAX_MODULES),
        .MAX_IMAGE   (MAX_IMAGE),
        .WORD_BITS   (WORD_BITS)
    ) u_front (
        .i_tvalid (s_tvalid),
        .o_tready (s_tready),
        .i_tdata  (s_tdata),
        .i_tuser  (s_tuser),
        .i_n      (r_n),
        .i_side   (r_side),
        .i_bpr    (r_bpr),
        .i_dn     (r_dn),
        .i_busy   (busy),
        .i_full   (q_full),
        .o_push   (push),
        .o_item   (f_item)
    );

    bmup_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    bmup_back #(
        .MAX_MODULES (MAX_MODULES),
        .MAX_IMAGE   (MAX_IMAGE),
        .WORD_BITS   (WORD_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_n       (r_n),
        .i_bw      (r_bw),
        .i_tot     (r_tot),
        .i_side    (r_side),
        .o_busy    (busy),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (pop),
        .o_tvalid  (m_tvalid),
        .i_tready  (m_tready),
        .o_pixel   (m_tdata),
        .o_status  (o_st)
    );

    assign m_tuser = o_st;

endmodule

@@ hdl/bmup_queue.sv @@
// ============================================================================
// bmup_queue
// Two-entry queue between the classifying front and the executing back.
// ============================================================================
module bmup_queue
    import bmup_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hdl/bmup_front.sv @@
// ============================================================================
// bmup_front
// Accepts input transactions and classifies them: load validity, read status.
// ============================================================================
module bmup_front
    import bmup_pkg::*;
#(
    parameter int MAX_MODULES = MAX_MODULES_DEF,
    parameter int MAX_IMAGE   = MAX_IMAGE_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
)(
    input  logic                                  i_tvalid,
    output logic                                  o_tready,
    input  logic [SDATA_W-1:0]                    i_tdata,
    input  logic [0:0]                            i_tuser,
    input  logic [f_nw(MAX_MODULES)-1:0]          i_n,
    input  logic [f_siw(MAX_MODULES, MAX_IMAGE)-1:0] i_side,
    input  logic [f_siw(MAX_MODULES, MAX_IMAGE)-1:0] i_bpr,
    input  logic                                  i_dn,
    input  logic                                  i_busy,
    input  logic                                  i_full,
    output logic                                  o_push,
    output t_item                                 o_item
);

    localparam int WPR = (MAX_MODULES + WORD_BITS - 1) / WORD_BITS;

    logic [ROW_W-1:0] w_row;
    logic [COL_W-1:0] w_col;

    assign w_row = i_tdata[ROW_W-1:0];
    assign w_col = i_tdata[ROW_W +: COL_W];

    assign o_tready = !i_busy && !i_full;
    assign o_push   = i_tvalid && o_tready;

    // classification
    always_comb begin
        o_item.op    = t_op'(i_tuser[0]);
        o_item.row   = w_row;
        o_item.col   = w_col;
        o_item.bits  = i_tdata[ROW_W + COL_W +: BITS_W];
        o_item.wr_ok = (32'(w_row) < 32'(i_n)) && (32'(w_col) < 32'(WPR));
        if (i_dn) begin
            o_item.status = ST_DOWNSCALE;
        end else if ((32'(w_row) >= 32'(i_side)) || (32'(w_col) >= 32'(i_bpr))) begin
            o_item.status = ST_RANGE;
        end else begin
            o_item.status = ST_OK;
        end
    end

endmodule

@@ hdl/bmup_back.sv @@
// ============================================================================
// bmup_back
// Pixel-to-module map table, module store and the read pipeline.
// ============================================================================
module bmup_back
    import bmup_pkg::*;
#(
    parameter int MAX_MODULES = MAX_MODULES_DEF,
    parameter int MAX_IMAGE   = MAX_IMAGE_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
)(
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [f_nw(MAX_MODULES)-1:0]             i_n,
    input  logic [BW_W-1:0]                          i_bw,
    input  logic [f_totw(MAX_MODULES)-1:0]           i_tot,
    input  logic [f_siw(MAX_MODULES, MAX_IMAGE)-1:0] i_side,
    output logic                                     o_busy,
    input  logic                                     i_q_valid,
    input  t_item                                    i_q_item,
    output logic                                     o_pop,
    output logic                                     o_tvalid,
    input  logic                                     i_tready,
    output logic [PIX_W-1:0]                         o_pixel,
    output t_status                                  o_status
);

    localparam int NW   = f_nw(MAX_MODULES);
    localparam int MW   = f_totw(MAX_MODULES);
    localparam int SIW  = f_siw(MAX_MODULES, MAX_IMAGE);
    localparam int RW   = SIW + 1;
    localparam int WPR  = (MAX_MODULES + WORD_BITS - 1) / WORD_BITS;
    localparam int RWID = WPR * WORD_BITS;
    localparam int RCW  = $clog2(RWID);
    localparam int RAW  = $clog2(MAX_MODULES);
    localparam int WIW  = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int TD   = (MAX_IMAGE + LANES - 1) / LANES;
    localparam int TIW  = $clog2(TD);
    localparam int XW   = $clog2(TD * LANES);
    localparam logic [XW-1:0] X_LAST = XW'(TD * LANES - 1);

    typedef enum logic [1:0] {S_IDLE, S_PREP1, S_PREP2, S_RUN} t_state;

    // memories
    logic [RWID-1:0]     r_store [MAX_MODULES];
    logic [LANES*MW-1:0] r_map   [TD];

    // sweep state
    t_state              r_st;
    logic [XW-1:0]       r_x;
    logic [MW-1:0]       r_q;
    logic [RW-1:0]       r_r;
    logic [LANES*MW-1:0] r_lane;
    logic [MW-1:0]       n_q;
    logic [RW-1:0]       n_r;
    logic [RW-1:0]       w_radd;
    logic [LANES*MW-1:0] n_lane;

    // pipeline
    logic                adv;
    logic                r1_v;
    t_op                 r1_op;
    t_status             r1_status;
    logic [COL_W-1:0]    r1_col;
    logic [LANE_W-1:0]   r1_ylane;
    logic [LANES*MW-1:0] r_mapx;
    logic [LANES*MW-1:0] r_mapy;
    logic [MW-1:0]       w_my;
    logic [MW-1:0]       w_mrow;
    logic                w_rin;
    logic [LANES-1:0]    w_xok;

    logic                r2_v;
    t_op                 r2_op;
    t_status             r2_status;
    logic                r2_rowlight;
    logic [LANES*MW-1:0] r2_mx;
    logic [LANES-1:0]    r2_xok;
    logic [RWID-1:0]     r_rowd;
    logic [PIX_W-1:0]    w_pix;

    logic                r_ov;
    logic [PIX_W-1:0]    r_opix;
    t_status             r_ost;

    assign o_busy   = (r_st != S_IDLE);
    assign adv      = !r_ov || i_tready;
    assign o_pop    = adv && i_q_valid && !o_busy;
    assign o_tvalid = r_ov;
    assign o_pixel  = r_opix;
    assign o_status = r_ost;

    // one DDA step of the pixel-to-module map: m(x) = ((x+1)*N-1) / S
    always_comb begin
        w_radd = r_r + RW'(i_tot);
        if (w_radd >= RW'(i_side)) begin
            n_r = w_radd - RW'(i_side);
            n_q = r_q + MW'(1);
        end else begin
            n_r = w_radd;
            n_q = r_q;
        end
        n_lane = r_lane;
        n_lane[r_x[LANE_W-1:0]*MW +: MW] = r_q;
    end

    // map table rebuild after reset and after any register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_PREP1;
            r_x  <= '0;
        end else if (i_cfg_we) begin
            r_st <= S_PREP1;
        end else begin
            case (r_st)
                S_PREP1: r_st <= S_PREP2;
                S_PREP2: begin
                    r_st <= S_RUN;
                    r_x  <= '0;
                    r_q  <= '0;
                    r_r  <= RW'(i_tot) - RW'(1);
                end
                S_RUN: begin
                    r_x    <= r_x + XW'(1);
                    r_q    <= n_q;
                    r_r    <= n_r;
                    r_lane <= n_lane;
                    if (r_x == X_LAST) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // map table: sweep write, two reads per popped transaction
    always_ff @(posedge i_clk) begin
        if (r_st == S_RUN && r_x[LANE_W-1:0] == LANE_W'(LANES - 1)) begin
            r_map[r_x[XW-1:LANE_W]] <= n_lane;
        end
        if (o_pop) begin
            r_mapx <= r_map[TIW'(i_q_item.col)];
            r_mapy <= r_map[TIW'(i_q_item.row >> LANE_W)];
        end
    end

    // stage 1: module row of the image row, pixel columns inside the image
    always_comb begin
        w_my   = r_mapy[r1_ylane*MW +: MW];
        w_mrow = w_my - MW'(i_bw);
        w_rin  = (w_my >= MW'(i_bw)) && (w_mrow < MW'(i_n));
        for (int b = 0; b < LANES; b++) begin
            w_xok[b] = (32'({r1_col, 3'b000}) + 32'(b)) < 32'(i_side);
        end
    end

    // module store: word write at pop, row read on stage 1 advance
    always_ff @(posedge i_clk) begin
        if (o_pop && i_q_item.op == OP_LOAD && i_q_item.wr_ok) begin
            r_store[RAW'(i_q_item.row)][WIW'(i_q_item.col)*WORD_BITS +: WORD_BITS]
                <= WORD_BITS'(i_q_item.bits);
        end
        if (adv) begin
            r_rowd <= r_store[RAW'(w_mrow)];
        end
    end

    // stage 2: pack the eight pixels, MSB is the leftmost
    always_comb begin
        logic [MW-1:0] mx;
        logic [MW-1:0] mc;
        logic          dark;
        w_pix = '0;
        for (int b = 0; b < LANES; b++) begin
            mx   = r2_mx[b*MW +: MW];
            mc   = mx - MW'(i_bw);
            dark = !r2_rowlight && (mx >= MW'(i_bw)) && (mc < MW'(i_n))
                   && r_rowd[RCW'(mc)];
            w_pix[PIX_W-1-b] = r2_xok[b] && !dark;
        end
        if (r2_status != ST_OK) begin
            w_pix = '0;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_op       <= i_q_item.op;
            r1_status   <= i_q_item.status;
            r1_col      <= i_q_item.col;
            r1_ylane    <= i_q_item.row[LANE_W-1:0];
            r2_op       <= r1_op;
            r2_status   <= r1_status;
            r2_rowlight <= !w_rin;
            r2_mx       <= r_mapx;
            r2_xok      <= w_xok;
            r_opix      <= w_pix;
            r_ost       <= r2_status;
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r1_v <= o_pop;
            r2_v <= r1_v;
            r_ov <= r2_v && (r2_op == OP_READ);
        end
    end

`include "binary_matrix_upscale_packer_assert.svh"

    `BMUP_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, r_ov && r_ost != ST_OK, r_opix == '0)
    `BMUP_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, adv && r2_v && r2_op == OP_LOAD, !r_ov)
    `BMUP_ASSERT_IMPL(a_dda_step, i_clk, i_rst_n, r_st == S_RUN && $past(r_st == S_RUN) && !$past(i_cfg_we), r_q == $past(r_q) || r_q == MW'($past(r_q) + MW'(1)))

endmodule
